// ===== sv/dqd_pkg.sv =====
// Package for the double-ended queue with delete.
// Holds field widths, operation and status codes, controller states and
// the command and status structs between controller and datapath.
package dqd_pkg;

  localparam int FUNC_W = 3;
  localparam int VAL_W  = 32;
  localparam int STS_W  = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_F = 3'd0,
    FN_POP_F  = 3'd1,
    FN_APPEND = 3'd2,
    FN_TAKE_B = 3'd3,
    FN_DELETE = 3'd4,
    FN_CLEAR  = 3'd5
  } func_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK     = 2'd0,
    STS_NOELEM = 2'd1,
    STS_FULL   = 2'd2
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_PUSH_F,
    DP_APPEND,
    DP_RD_FRONT,
    DP_RD_BACK,
    DP_POP_F,
    DP_TAKE_B,
    DP_SCAN_START,
    DP_SCAN_NEXT,
    DP_DEL_LAST,
    DP_SHIFT_START,
    DP_SHIFT_STEP,
    DP_SHIFT_END,
    DP_CLEAR,
    DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   set_sts;
    sts_t   sts;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  empty;
    logic  full;
    logic  match;
    logic  scan_last;
    logic  shift_last;
    logic  out_busy;
  } dp_stat_t;

endpackage

// ===== sv/dqd_if.sv =====
// Valid/ready channel interfaces for the double-ended queue.
// Depends on dqd_pkg for field widths.
interface dqd_in_if;
  logic                             valid;
  logic                             ready;
  logic [dqd_pkg::FUNC_W-1:0]       func;
  logic signed [dqd_pkg::VAL_W-1:0] value_in;

  modport source (output valid, func, value_in, input ready);
  modport sink   (input valid, func, value_in, output ready);
endinterface

interface dqd_out_if;
  logic                             valid;
  logic                             ready;
  logic [dqd_pkg::STS_W-1:0]        status;
  logic signed [dqd_pkg::VAL_W-1:0] value_out;
  logic [dqd_pkg::OCC_W-1:0]        occupancy;

  modport source (output valid, status, value_out, occupancy, input ready);
  modport sink   (input valid, status, value_out, occupancy, output ready);
endinterface

// ===== sv/dqd_ctrl.sv =====
// Controller state machine for the double-ended queue.
// Sequences each transaction through the datapath; depends on dqd_pkg.
module dqd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dqd_pkg::dp_stat_t stat,
  output dqd_pkg::dp_cmd_t  cmd
);

  dqd_pkg::state_t state_r;
  dqd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dqd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.op      = dqd_pkg::DP_NOP;
    cmd.set_sts = 1'b0;
    cmd.sts     = dqd_pkg::STS_OK;
    in_ready    = 1'b0;
    case (state_r)
      dqd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = dqd_pkg::DP_LOAD;
          state_nxt = dqd_pkg::S_EXEC;
        end
      end
      dqd_pkg::S_EXEC: begin
        state_nxt = dqd_pkg::S_DONE;
        case (stat.func)
          dqd_pkg::FN_PUSH_F, dqd_pkg::FN_APPEND: begin
            if (stat.full) begin
              cmd.set_sts = 1'b1;
              cmd.sts     = dqd_pkg::STS_FULL;
            end else if (stat.func == dqd_pkg::FN_PUSH_F) begin
              cmd.op = dqd_pkg::DP_PUSH_F;
            end else begin
              cmd.op = dqd_pkg::DP_APPEND;
            end
          end
          dqd_pkg::FN_POP_F, dqd_pkg::FN_TAKE_B: begin
            if (stat.empty) begin
              cmd.set_sts = 1'b1;
              cmd.sts     = dqd_pkg::STS_NOELEM;
            end else begin
              cmd.op    = (stat.func == dqd_pkg::FN_POP_F) ? dqd_pkg::DP_RD_FRONT
                                                           : dqd_pkg::DP_RD_BACK;
              state_nxt = dqd_pkg::S_RD_WAIT;
            end
          end
          dqd_pkg::FN_DELETE: begin
            if (stat.empty) begin
              cmd.set_sts = 1'b1;
              cmd.sts     = dqd_pkg::STS_NOELEM;
            end else begin
              cmd.op    = dqd_pkg::DP_SCAN_START;
              state_nxt = dqd_pkg::S_SCAN;
            end
          end
          dqd_pkg::FN_CLEAR: begin
            cmd.op = dqd_pkg::DP_CLEAR;
          end
          default: begin
            cmd.op = dqd_pkg::DP_NOP;
          end
        endcase
      end
      dqd_pkg::S_RD_WAIT: begin
        cmd.op    = (stat.func == dqd_pkg::FN_POP_F) ? dqd_pkg::DP_POP_F
                                                     : dqd_pkg::DP_TAKE_B;
        state_nxt = dqd_pkg::S_DONE;
      end
      dqd_pkg::S_SCAN: begin
        if (stat.match) begin
          if (stat.scan_last) begin
            cmd.op    = dqd_pkg::DP_DEL_LAST;
            state_nxt = dqd_pkg::S_DONE;
          end else begin
            cmd.op    = dqd_pkg::DP_SHIFT_START;
            state_nxt = dqd_pkg::S_SHIFT;
          end
        end else if (stat.scan_last) begin
          cmd.set_sts = 1'b1;
          cmd.sts     = dqd_pkg::STS_NOELEM;
          state_nxt   = dqd_pkg::S_DONE;
        end else begin
          cmd.op = dqd_pkg::DP_SCAN_NEXT;
        end
      end
      dqd_pkg::S_SHIFT: begin
        if (stat.shift_last) begin
          cmd.op    = dqd_pkg::DP_SHIFT_END;
          state_nxt = dqd_pkg::S_DONE;
        end else begin
          cmd.op = dqd_pkg::DP_SHIFT_STEP;
        end
      end
      dqd_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = dqd_pkg::DP_OUT_LOAD;
          state_nxt = dqd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dqd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dqd_datapath.sv =====
// Datapath for the double-ended queue: circular entry memory, head and
// count registers, scan index and output register. Depends on dqd_pkg.
module dqd_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dqd_pkg::dp_cmd_t                 cmd,
  output dqd_pkg::dp_stat_t                stat,
  input  logic [dqd_pkg::FUNC_W-1:0]       in_func,
  input  logic signed [dqd_pkg::VAL_W-1:0] in_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [dqd_pkg::STS_W-1:0]        out_status,
  output logic signed [dqd_pkg::VAL_W-1:0] out_value,
  output logic [dqd_pkg::OCC_W-1:0]        out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [dqd_pkg::VAL_W-1:0] mem [DEPTH];
  logic [dqd_pkg::VAL_W-1:0] rd_data_r;

  logic [AW-1:0]             head_r;
  logic [AW-1:0]             head_nxt;
  logic [CW-1:0]             count_r;
  logic [CW-1:0]             count_nxt;
  logic [CW-1:0]             idx_r;
  logic [CW-1:0]             idx_nxt;
  dqd_pkg::func_t            func_r;
  logic [dqd_pkg::VAL_W-1:0] val_r;
  dqd_pkg::sts_t             sts_r;
  logic [dqd_pkg::VAL_W-1:0] vout_r;
  logic                      out_valid_r;
  logic [dqd_pkg::STS_W-1:0] out_status_r;
  logic [dqd_pkg::VAL_W-1:0] out_value_r;
  logic [dqd_pkg::OCC_W-1:0] out_occ_r;

  logic [AW-1:0]             raddr;
  logic [AW-1:0]             waddr;
  logic                      we;
  logic [AW-1:0]             head_p1;
  logic [AW-1:0]             head_m1;
  logic [CW-1:0]             cnt_m1;
  logic [CW-1:0]             idx_p1;
  logic [CW-1:0]             idx_p2;
  logic [CW+dqd_pkg::OCC_W-1:0] occ_ext;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(pos);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign head_p1 = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_m1 = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign cnt_m1  = count_r - 1'b1;
  assign idx_p1  = idx_r + 1'b1;
  assign idx_p2  = idx_r + CW'(2);
  assign occ_ext = (CW+dqd_pkg::OCC_W)'(count_r);

  assign stat.func       = func_r;
  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r == CW'(DEPTH));
  assign stat.match      = (rd_data_r == val_r);
  assign stat.scan_last  = ((CW+1)'(idx_r) + (CW+1)'(1)) == (CW+1)'(count_r);
  assign stat.shift_last = ((CW+1)'(idx_r) + (CW+1)'(2)) == (CW+1)'(count_r);
  assign stat.out_busy   = out_valid_r && !out_ready;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    raddr     = head_r;
    waddr     = head_r;
    we        = 1'b0;
    case (cmd.op)
      dqd_pkg::DP_PUSH_F: begin
        we        = 1'b1;
        waddr     = head_m1;
        head_nxt  = head_m1;
        count_nxt = count_r + 1'b1;
      end
      dqd_pkg::DP_APPEND: begin
        we        = 1'b1;
        waddr     = phys(head_r, count_r);
        count_nxt = count_r + 1'b1;
      end
      dqd_pkg::DP_RD_FRONT: begin
        raddr = head_r;
      end
      dqd_pkg::DP_RD_BACK: begin
        raddr = phys(head_r, cnt_m1);
      end
      dqd_pkg::DP_POP_F: begin
        head_nxt  = head_p1;
        count_nxt = cnt_m1;
      end
      dqd_pkg::DP_TAKE_B, dqd_pkg::DP_DEL_LAST: begin
        count_nxt = cnt_m1;
      end
      dqd_pkg::DP_SCAN_START: begin
        idx_nxt = '0;
        raddr   = head_r;
      end
      dqd_pkg::DP_SCAN_NEXT: begin
        idx_nxt = idx_p1;
        raddr   = phys(head_r, idx_p1);
      end
      dqd_pkg::DP_SHIFT_START: begin
        raddr = phys(head_r, idx_p1);
      end
      dqd_pkg::DP_SHIFT_STEP: begin
        we      = 1'b1;
        waddr   = phys(head_r, idx_r);
        idx_nxt = idx_p1;
        raddr   = phys(head_r, idx_p2);
      end
      dqd_pkg::DP_SHIFT_END: begin
        we        = 1'b1;
        waddr     = phys(head_r, idx_r);
        count_nxt = cnt_m1;
      end
      dqd_pkg::DP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        head_nxt = head_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= (cmd.op == dqd_pkg::DP_PUSH_F || cmd.op == dqd_pkg::DP_APPEND)
                    ? val_r : rd_data_r;
    end
    rd_data_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cmd.op == dqd_pkg::DP_OUT_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.op == dqd_pkg::DP_LOAD) begin
      func_r <= dqd_pkg::func_t'(in_func);
      val_r  <= in_value;
      sts_r  <= dqd_pkg::STS_OK;
      vout_r <= '0;
    end else begin
      if (cmd.set_sts) begin
        sts_r <= cmd.sts;
      end
      if (cmd.op == dqd_pkg::DP_POP_F || cmd.op == dqd_pkg::DP_TAKE_B) begin
        vout_r <= rd_data_r;
      end
    end
    if (cmd.op == dqd_pkg::DP_OUT_LOAD) begin
      out_status_r <= sts_r;
      out_value_r  <= vout_r;
      out_occ_r    <= occ_ext[dqd_pkg::OCC_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value     = out_value_r;
  assign out_occupancy = out_occ_r;

endmodule

// ===== sv/double_ended_queue_with_delete.sv =====
// Double-ended queue of DEPTH signed 32-bit entries with delete by value.
// Push, append, clear, unused codes and refused or empty operations are executed and
// their result registered; pop and take first wait for an entry memory read; delete
// walks the n entries held, as the one-read, one-write entry memory scans and shifts one
// entry a cycle. A new transaction is taken in the cycle after the result is registered,
// and a stalled result holds it off. Reset empties the queue.
module double_ended_queue_with_delete #(
  parameter int DEPTH = 16
) (
  input logic         clk,
  input logic         rst_n,
  dqd_in_if.sink      in_ch,
  dqd_out_if.source   out_ch
);

  dqd_pkg::dp_cmd_t  cmd;
  dqd_pkg::dp_stat_t stat;

  dqd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dqd_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_func       (in_ch.func),
    .in_value      (in_ch.value_in),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_status    (out_ch.status),
    .out_value     (out_ch.value_out),
    .out_occupancy (out_ch.occupancy)
  );

endmodule
